/* rtl/pbb_pkg.sv */
// Shared types, constants and helpers of the primitive bounding box block.
// Used by pbb_box, pbb_cordic, pbb_sqrt and primitive_bounding_box; depends on nothing.
package pbb_pkg;

  localparam int PW       = 36;
  localparam int CW       = 33;
  localparam int ATAN_LEN = 30;

  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_POINT   = 3'd1;
  localparam logic [2:0] KIND_SEGMENT = 3'd2;
  localparam logic [2:0] KIND_CIRCLE  = 3'd3;
  localparam logic [2:0] KIND_ELLIPSE = 3'd4;
  localparam logic [2:0] KIND_ARC     = 3'd5;

  localparam longint PI_Q            = 64'sd3373259426;
  localparam longint HALF_PI_Q       = 64'sd1686629713;
  localparam longint TWO_PI_Q        = 64'sd6746518852;
  localparam longint THREE_HALF_PI_Q = 64'sd5059889139;
  localparam longint GAIN_Q          = 64'sd652032874;

  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  typedef struct packed {
    logic                 clear;
    logic                 add;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } box_cmd_t;

  typedef struct packed {
    logic               has_points;
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
  } box_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > 36'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/pbb_box.sv */
// Box accumulator: saturates one point a cycle and widens the box with it.
// Depends on pbb_pkg.
module pbb_box import pbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  box_cmd_t   cmd,
  output box_state_t box
);

  logic signed [31:0] sx, sy;

  assign sx = sat32(cmd.px);
  assign sy = sat32(cmd.py);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      box <= '0;
    end else if (cmd.add) begin
      if (!box.has_points) begin
        box.has_points <= 1'b1;
        box.low_x      <= sx;
        box.high_x     <= sx;
        box.low_y      <= sy;
        box.high_y     <= sy;
      end else begin
        if (sx < box.low_x)  box.low_x  <= sx;
        if (sx > box.high_x) box.high_x <= sx;
        if (sy < box.low_y)  box.low_y  <= sy;
        if (sy > box.high_y) box.high_y <= sy;
      end
    end
  end

endmodule

/* rtl/pbb_cordic.sv */
// Iterative CORDIC in rotation mode: angle reduction, then one micro-rotation a cycle.
// Depends on pbb_pkg for the arctangent table and angle constants.
module pbb_cordic import pbb_pkg::*; #(
  parameter int AW    = 35,
  parameter int STEPS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] angle,
  output logic                 done,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);
  localparam logic signed [AW-1:0] PI_A   = AW'(PI_Q);
  localparam logic signed [AW-1:0] HALF_A = AW'(HALF_PI_Q);
  localparam logic signed [AW-1:0] TWO_A  = AW'(TWO_PI_Q);
  localparam logic signed [CW-1:0] GAIN_C = CW'(GAIN_Q);

  typedef enum logic [2:0] {C_IDLE, C_MOD, C_WRAP, C_FOLD, C_ITER} cstate_t;

  cstate_t              state;
  logic signed [AW-1:0] z;
  logic signed [CW-1:0] x, y;
  logic                 flip;
  logic [4:0]           i;

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      flip  <= 1'b0;
    end else begin
      done <= (state == C_ITER) && (i == LAST);
      case (state)
        C_IDLE: begin
          if (start) begin
            z     <= angle;
            flip  <= 1'b0;
            state <= C_MOD;
          end
        end
        C_MOD: begin
          if (z >= TWO_A) begin
            z <= z - TWO_A;
          end else if (z <= -TWO_A) begin
            z <= z + TWO_A;
          end else begin
            state <= C_WRAP;
          end
        end
        C_WRAP: begin
          if (z > PI_A) begin
            z <= z - TWO_A;
          end else if (z < -PI_A) begin
            z <= z + TWO_A;
          end
          state <= C_FOLD;
        end
        C_FOLD: begin
          if (z > HALF_A) begin
            z    <= z - PI_A;
            flip <= 1'b1;
          end else if (z < -HALF_A) begin
            z    <= z + PI_A;
            flip <= 1'b1;
          end
          x     <= GAIN_C;
          y     <= '0;
          i     <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[AW-1]) begin
            x <= x - (y >>> i);
            y <= y + (x >>> i);
            z <= z - AW'(ATAN_Q30[i]);
          end else begin
            x <= x + (y >>> i);
            y <= y - (x >>> i);
            z <= z + AW'(ATAN_Q30[i]);
          end
          i <= i + 5'd1;
          if (i == LAST) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pbb_sqrt.sv */
// Restoring square root, one result bit a cycle, rounded to nearest.
// Depends on pbb_pkg for the root width.
module pbb_sqrt import pbb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   radicand,
  output logic          done,
  output logic [CW-1:0] root
);

  typedef enum logic [1:0] {Q_IDLE, Q_RUN, Q_FIN} qstate_t;

  qstate_t     state;
  logic [63:0] rem, res, bitv, trial;
  logic [4:0]  k;

  assign bitv  = 64'd1 << {k, 1'b0};
  assign trial = res + bitv;
  assign root  = res[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == Q_FIN);
      case (state)
        Q_IDLE: begin
          if (start) begin
            rem   <= radicand;
            res   <= '0;
            k     <= 5'd31;
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          if (k == 5'd0) begin
            state <= Q_FIN;
          end else begin
            k <= k - 5'd1;
          end
        end
        Q_FIN: begin
          if (rem > res) res <= res + 64'd1;
          state <= Q_IDLE;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

/* rtl/primitive_bounding_box.sv */
// Top level of the primitive bounding box block: sequencer, shared multiplier, result register.
// Depends on pbb_pkg, pbb_box, pbb_cordic and pbb_sqrt.
//
// Each item adds a point, segment, circle, rotated ellipse or arc (Q16.16) to an
// axis-aligned box, or clears it, and one result item reports the box afterwards.
// The block takes one item at a time and is not ready until its result is in the
// output register. An ellipse runs the CORDIC loop once, then the shared multiplier and
// the 32-step square root once for the width and once for the height; an arc runs the
// CORDIC loop and the multiplier once for each end angle, all of them in sequence.
module primitive_bounding_box import pbb_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x1, y1, x2, y2, radius, axis_a, axis_b, tilt_angle, arc_begin, arc_end
  input  logic [287:0] s_axis_tdata,
  // kind
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // box_valid, min_x, min_y, max_x, max_y
  output logic [135:0] m_axis_tdata
);

  localparam int AW  = ((50 - FRAC_BITS) > 34) ? (51 - FRAC_BITS) : 35;
  localparam int ASH = 30 - FRAC_BITS;
  localparam logic signed [AW-1:0] TWO_A   = AW'(TWO_PI_Q);
  localparam logic signed [AW-1:0] HALF_A  = AW'(HALF_PI_Q);
  localparam logic signed [AW-1:0] PI_A    = AW'(PI_Q);
  localparam logic signed [AW-1:0] THREE_A = AW'(THREE_HALF_PI_Q);

  typedef enum logic [2:0] {S_IDLE, S_PT, S_ROT, S_MUL, S_ROOT, S_DONE} state_t;

  function automatic logic signed [AW-1:0] to_angle(input logic signed [19:0] a);
    return AW'(a) <<< ASH;
  endfunction

  state_t               state;
  logic [2:0]           cnt;
  logic                 phase;
  logic [2:0]           kind;
  logic signed [31:0]   x1, y1, x2, y2;
  logic [30:0]          radius, axis_a, axis_b;
  logic signed [19:0]   tilt, arc_b, arc_e;
  logic                 rot_start, root_start;
  logic [63:0]          root_in, acc;
  logic signed [65:0]   prod, prod_adj;
  logic signed [CW-1:0] t0, t1, rnd;
  logic [CW-1:0]        wv, hv;
  logic                 out_valid;
  box_state_t           out_box;

  logic                 accept;
  logic signed [AW-1:0] rot_angle, ang_b, ang_e, lim;
  logic                 rot_done, root_done;
  logic signed [CW-1:0] cos_v, sin_v, abs_c, abs_s, opa, opb, r_c, p_c, q_c;
  logic [CW-1:0]        root_v;
  logic signed [PW-1:0] xe, ye, re, we, he, pt_x, pt_y;
  logic                 pt_en, pt_last;
  box_cmd_t             cmd;
  box_state_t           box;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_box.high_y, out_box.high_x, out_box.low_y,
                          out_box.low_x, out_box.has_points};

  assign ang_b     = to_angle(arc_b);
  assign ang_e     = to_angle(arc_e);
  assign rot_angle = (kind == KIND_ARC) ? (phase ? ang_e : ang_b) : to_angle(tilt);

  pbb_cordic #(.AW(AW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(rot_start), .angle(rot_angle),
    .done(rot_done), .cos_o(cos_v), .sin_o(sin_v)
  );

  pbb_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(root_in),
    .done(root_done), .root(root_v)
  );

  assign abs_c    = cos_v[CW-1] ? -cos_v : cos_v;
  assign abs_s    = sin_v[CW-1] ? -sin_v : sin_v;
  assign r_c      = $signed({2'b00, radius});
  assign p_c      = $signed({2'b00, phase ? axis_b : axis_a});
  assign q_c      = $signed({2'b00, phase ? axis_a : axis_b});
  assign prod_adj = prod + (66'sd1 <<< 29);
  assign rnd      = prod_adj[30 +: CW];

  always_comb begin
    opa = '0;
    opb = '0;
    if (kind == KIND_ARC) begin
      case (cnt)
        3'd0:    begin opa = r_c; opb = cos_v; end
        3'd1:    begin opa = r_c; opb = sin_v; end
        default: begin opa = '0;  opb = '0;    end
      endcase
    end else begin
      case (cnt)
        3'd0:    begin opa = p_c; opb = abs_c; end
        3'd1:    begin opa = q_c; opb = abs_s; end
        3'd2:    begin opa = t0;  opb = t0;    end
        3'd3:    begin opa = t1;  opb = t1;    end
        default: begin opa = '0;  opb = '0;    end
      endcase
    end
  end

  assign xe = PW'(x1);
  assign ye = PW'(y1);
  assign re = PW'(r_c);
  assign we = PW'($signed({1'b0, wv}));
  assign he = PW'($signed({1'b0, hv}));

  always_comb begin
    pt_x    = xe;
    pt_y    = ye;
    pt_en   = 1'b1;
    pt_last = 1'b1;
    lim     = TWO_A;
    case (kind)
      KIND_SEGMENT: begin
        pt_last = (cnt != 3'd0);
        if (cnt != 3'd0) begin
          pt_x = PW'(x2);
          pt_y = PW'(y2);
        end
      end
      KIND_CIRCLE: begin
        pt_last = (cnt != 3'd0);
        pt_x    = (cnt == 3'd0) ? xe - re : xe + re;
        pt_y    = (cnt == 3'd0) ? ye - re : ye + re;
      end
      KIND_ELLIPSE: begin
        pt_last = (cnt != 3'd0);
        pt_x    = (cnt == 3'd0) ? xe - we : xe + we;
        pt_y    = (cnt == 3'd0) ? ye - he : ye + he;
      end
      KIND_ARC: begin
        pt_last = 1'b0;
        case (cnt)
          3'd0: ;
          3'd1: begin lim = TWO_A;   pt_x = xe + re; end
          3'd2: begin lim = HALF_A;  pt_y = ye + re; end
          3'd3: begin lim = PI_A;    pt_x = xe - re; end
          3'd4: begin lim = THREE_A; pt_y = ye - re; end
          default: begin
            pt_x = xe + PW'(t0);
            pt_y = ye + PW'(t1);
          end
        endcase
        if (cnt >= 3'd1 && cnt <= 3'd4) pt_en = (ang_b <= lim) && (ang_e >= lim);
      end
      default: ;
    endcase
  end

  assign cmd.clear = accept && (s_axis_tuser == KIND_CLEAR);
  assign cmd.add   = (state == S_PT) && pt_en;
  assign cmd.px    = pt_x;
  assign cmd.py    = pt_y;

  pbb_box u_box (.clk(clk), .rst(rst), .cmd(cmd), .box(box));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      phase      <= 1'b0;
      rot_start  <= 1'b0;
      root_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rot_start  <= (accept && (s_axis_tuser == KIND_ELLIPSE)) ||
                    ((state == S_PT) && (kind == KIND_ARC) &&
                     ((cnt == 3'd4) || ((cnt == 3'd5) && !phase)));
      root_start <= (state == S_MUL) && (kind != KIND_ARC) && (cnt == 3'd4);
      if (out_valid && m_axis_tready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind   <= s_axis_tuser;
            x1     <= s_axis_tdata[31:0];
            y1     <= s_axis_tdata[63:32];
            x2     <= s_axis_tdata[95:64];
            y2     <= s_axis_tdata[127:96];
            radius <= s_axis_tdata[158:128];
            axis_a <= s_axis_tdata[189:159];
            axis_b <= s_axis_tdata[220:190];
            tilt   <= s_axis_tdata[240:221];
            arc_b  <= s_axis_tdata[260:241];
            arc_e  <= s_axis_tdata[280:261];
            cnt    <= '0;
            phase  <= 1'b0;
            case (s_axis_tuser)
              KIND_POINT, KIND_SEGMENT, KIND_CIRCLE, KIND_ARC: state <= S_PT;
              KIND_ELLIPSE: state <= S_ROT;
              default: state <= S_DONE;
            endcase
          end
        end
        S_PT: begin
          cnt <= cnt + 3'd1;
          if (kind == KIND_ARC) begin
            if (cnt == 3'd4) begin
              state <= S_ROT;
            end else if (cnt == 3'd5) begin
              if (!phase) begin
                phase <= 1'b1;
                state <= S_ROT;
              end else begin
                state <= S_DONE;
              end
            end
          end else if (pt_last) begin
            state <= S_DONE;
          end
        end
        S_ROT: begin
          if (rot_done) begin
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= opa * opb;
          if (cnt == 3'd1) t0 <= rnd;
          if (cnt == 3'd2) t1 <= rnd;
          if ((kind == KIND_ARC) && (cnt == 3'd2)) begin
            cnt   <= 3'd5;
            state <= S_PT;
          end else begin
            cnt <= cnt + 3'd1;
          end
          if (kind != KIND_ARC) begin
            if (cnt == 3'd3) acc <= prod[63:0];
            if (cnt == 3'd4) begin
              root_in <= acc + prod[63:0];
              state   <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (root_done) begin
            cnt <= '0;
            if (!phase) begin
              wv    <= root_v;
              phase <= 1'b1;
              state <= S_MUL;
            end else begin
              hv    <= root_v;
              state <= S_PT;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_box   <= box;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pbb_checker.sv */
// Port-level checker of the primitive bounding box block and its bind to the top level.
// Depends on primitive_bounding_box port names only.
module pbb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input item accepted back to back");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[128:1] == 128'd0)
    else $error("empty box reports nonzero corners");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      ($signed(m_axis_tdata[32:1]) <= $signed(m_axis_tdata[96:65])) &&
      ($signed(m_axis_tdata[64:33]) <= $signed(m_axis_tdata[128:97])))
    else $error("box corners out of order");

endmodule

bind primitive_bounding_box pbb_checker u_pbb_checker (.*);

/* tb/pbb_checker.sv */
// Checker of the primitive bounding box block: watches both streams, predicts each box
// report from the accepted input items and compares it field by field.
// Depends on pbb_pkg for the angle constants and the arctangent table.
module pbb_tb_checker import pbb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // x1, y1, x2, y2, radius, axis_a, axis_b, tilt_angle, arc_begin, arc_end
  input  logic [287:0] s_axis_tdata,
  // kind
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // box_valid, min_x, min_y, max_x, max_y
  input  logic [135:0] m_axis_tdata,
  output int           errors,
  output int           outstanding,
  output int           reports_seen
);

  localparam int FRAC = 16;
  localparam int STEPS = 20;

  logic [128:0] box_queue [$];

  bit             has_pts;
  logic [31:0]    lo_x, lo_y, hi_x, hi_y;

  function automatic longint mul_frac(input longint a, input longint t);
    return (a * t + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint to_q30(input logic [19:0] raw);
    return longint'($signed(raw)) * (64'sd1 <<< (30 - FRAC));
  endfunction

  task automatic rotate(input longint th, output longint c, output longint s);
    longint r, x, y, nx;
    bit flip;
    r = th % TWO_PI_Q;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    if (r > PI_Q) r -= TWO_PI_Q;
    if (r < -PI_Q) r += TWO_PI_Q;
    if (r > HALF_PI_Q) begin
      r -= PI_Q;
      flip = 1;
    end else if (r < -HALF_PI_Q) begin
      r += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += ATAN_Q30[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint rounded_root(input bit [63:0] v);
    bit [63:0] rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (rem > res) res++;
    return longint'(res);
  endfunction

  function automatic longint extent(input longint p, input longint q, input longint c,
                                    input longint s);
    bit [63:0] pc, qs;
    pc = mul_frac(p, c < 0 ? -c : c);
    qs = mul_frac(q, s < 0 ? -s : s);
    return rounded_root(pc * pc + qs * qs);
  endfunction

  function automatic logic [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic grow(input longint x, input longint y);
    logic [31:0] px, py;
    px = clamp(x);
    py = clamp(y);
    if (!has_pts) begin
      has_pts = 1;
      lo_x = px;
      hi_x = px;
      lo_y = py;
      hi_y = py;
    end else begin
      if ($signed(px) < $signed(lo_x)) lo_x = px;
      if ($signed(px) > $signed(hi_x)) hi_x = px;
      if ($signed(py) < $signed(lo_y)) lo_y = py;
      if ($signed(py) > $signed(hi_y)) hi_y = py;
    end
  endtask

  task automatic add_primitive(input logic [2:0] kind, input logic [287:0] d);
    longint x, y, r, a, b, c, s, w, h, ab, ae;
    x = longint'($signed(d[31:0]));
    y = longint'($signed(d[63:32]));
    r = longint'(d[158:128]);
    a = longint'(d[189:159]);
    b = longint'(d[220:190]);
    case (kind)
      KIND_CLEAR: begin
        has_pts = 0;
        lo_x = 0;
        lo_y = 0;
        hi_x = 0;
        hi_y = 0;
      end
      KIND_POINT: grow(x, y);
      KIND_SEGMENT: begin
        grow(x, y);
        grow(longint'($signed(d[95:64])), longint'($signed(d[127:96])));
      end
      KIND_CIRCLE: begin
        grow(x - r, y - r);
        grow(x + r, y + r);
      end
      KIND_ELLIPSE: begin
        rotate(to_q30(d[240:221]), c, s);
        w = extent(a, b, c, s);
        h = extent(b, a, c, s);
        grow(x - w, y - h);
        grow(x + w, y + h);
      end
      KIND_ARC: begin
        ab = to_q30(d[260:241]);
        ae = to_q30(d[280:261]);
        grow(x, y);
        if (ab <= TWO_PI_Q && ae >= TWO_PI_Q) grow(x + r, y);
        if (ab <= HALF_PI_Q && ae >= HALF_PI_Q) grow(x, y + r);
        if (ab <= PI_Q && ae >= PI_Q) grow(x - r, y);
        if (ab <= THREE_HALF_PI_Q && ae >= THREE_HALF_PI_Q) grow(x, y - r);
        rotate(ab, c, s);
        grow(x + mul_frac(r, c), y + mul_frac(r, s));
        rotate(ae, c, s);
        grow(x + mul_frac(r, c), y + mul_frac(r, s));
      end
      default: ;
    endcase
    box_queue.push_back({hi_y, hi_x, lo_y, lo_x, has_pts});
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t on report %0d: %s got %h expected %h",
             $realtime, reports_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [128:0] want;
    if (rst) begin
      has_pts <= 0;
      lo_x <= 0;
      lo_y <= 0;
      hi_x <= 0;
      hi_y <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (box_queue.size() == 0) begin
          report("unexpected item", m_axis_tdata[31:0], 0);
        end else begin
          want = box_queue.pop_front();
          if (m_axis_tdata[0] !== want[0]) report("box_valid", m_axis_tdata[0], want[0]);
          if (m_axis_tdata[32:1] !== want[32:1]) report("min_x", m_axis_tdata[32:1], want[32:1]);
          if (m_axis_tdata[64:33] !== want[64:33])
            report("min_y", m_axis_tdata[64:33], want[64:33]);
          if (m_axis_tdata[96:65] !== want[96:65])
            report("max_x", m_axis_tdata[96:65], want[96:65]);
          if (m_axis_tdata[128:97] !== want[128:97])
            report("max_y", m_axis_tdata[128:97], want[128:97]);
        end
        reports_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) add_primitive(s_axis_tuser, s_axis_tdata);
      outstanding = box_queue.size();
    end
  end

  initial begin
    errors = 0;
    outstanding = 0;
    reports_seen = 0;
  end

endmodule

/* tb/tb.sv */
// Top of the primitive bounding box testbench: clock, reset, directed and random
// primitives under varying idle patterns, and the verdict.
// Depends on pbb_pkg, primitive_bounding_box and pbb_tb_checker.
module tb import pbb_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  int errors;
  int outstanding;
  int reports_seen;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;

  primitive_bounding_box dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  pbb_tb_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .outstanding(outstanding), .reports_seen(reports_seen)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d reports outstanding", outstanding);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [287:0] pack(
    input logic [31:0] x1, input logic [31:0] y1, input logic [31:0] x2,
    input logic [31:0] y2, input logic [30:0] r, input logic [30:0] a,
    input logic [30:0] b, input logic [19:0] tilt, input logic [19:0] ab,
    input logic [19:0] ae);
    return {7'd0, ae, ab, tilt, b, a, r, y2, x2, y1, x1};
  endfunction

  task automatic send(input logic [2:0] kind, input logic [287:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = kind;
    s_axis_tdata = d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (outstanding != 0 || hold_cycles != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      default: return 32'($signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000);
    endcase
  endfunction

  function automatic logic [30:0] length();
    return $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(0, 32'h003FFFFF));
  endfunction

  task automatic send_random();
    logic [2:0] kind;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) kind = KIND_CLEAR;
    else if (pick < 8) kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
    else kind = 3'($urandom_range(1, 5));
    send(kind, pack(coord(), coord(), coord(), coord(), length(), length(), length(),
                    20'($urandom), 20'($urandom), 20'($urandom)));
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = KIND_CLEAR;
    m_axis_tready = 0;
    items_sent = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    send(KIND_POINT, pack(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(KIND_POINT, pack(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0));
    send(KIND_SEGMENT, pack(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 0, 0, 0, 0));
    send(KIND_CLEAR, '1);
    send(KIND_SPARE_A, '1);
    send(KIND_CIRCLE, pack(32'h7FFF0000, 32'h80010000, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 0, 0));
    send(KIND_CLEAR, 0);
    send(KIND_ELLIPSE, pack(0, 0, 0, 0, 0, 31'h00050000, 31'h00020000, 0, 0, 0));
    send(KIND_ELLIPSE, pack(32'h00100000, 32'hFFF00000, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF,
                            20'h7FFFF, 0, 0));
    send(KIND_ELLIPSE, pack(0, 0, 0, 0, 0, 31'h00030000, 0, 20'h80000, 0, 0));
    send(KIND_ELLIPSE, pack(0, 0, 0, 0, 0, 0, 31'h00030000, 20'h0C910, 0, 0));
    send(KIND_CLEAR, 0);
    send(KIND_ARC, pack(0, 0, 0, 0, 31'h00010000, 0, 0, 0, 0, 20'h6487F));
    send(KIND_ARC, pack(32'h00020000, 0, 0, 0, 31'h00020000, 0, 0, 0, 20'h80000, 20'h7FFFF));
    send(KIND_ARC, pack(0, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 20'h19220, 20'h4B660));
    send(KIND_ARC, pack(0, 0, 0, 0, 31'h00040000, 0, 0, 0, 20'h30000, 20'h10000));
    send(KIND_ARC, pack(32'h7FFFFFFF, 32'h80000000, 0, 0, 31'h7FFFFFFF, 0, 0, 0,
                        20'h80000, 20'h80000));
    send(KIND_SPARE_B, 0);
    send(KIND_CIRCLE, pack(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    send_idle_pct = 8;
    recv_idle_pct = 54;
    repeat (200) send_random();
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 8;
    repeat (200) send_random();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    repeat (100) send_random();
    s_axis_tvalid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (100) send_random();
    drain();

    $display("%0d primitives of every kind sent, %0d box reports checked", items_sent,
             reports_seen);
    $display("idle patterns on both sides, a long output hold-off and saturating coordinates");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
